>>> rtl/cds_pkg.sv
// shared types, constants and calendar helpers for the calendar date stepper
package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DAYS_W  = 16;
    localparam int REM_W   = 9;
    localparam int STAGE_W = 3;

    localparam logic [YEAR_W-1:0]  YEAR_LIMIT   = 14'd9999;
    localparam logic [REM_W-1:0]   LEAP_CYCLE   = 9'd400;
    localparam logic [REM_W-1:0]   CENTURY_1    = 9'd100;
    localparam logic [REM_W-1:0]   CENTURY_2    = 9'd200;
    localparam logic [REM_W-1:0]   CENTURY_3    = 9'd300;
    localparam logic [REM_W-1:0]   REM_LAST     = 9'd399;
    localparam logic [STAGE_W-1:0] REDUCE_TOP   = 3'd5;

    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR    = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_MAY    = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUL    = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG    = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_OCT    = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;

    localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
    localparam logic [DAY_W-1:0]   DAYS_LONG    = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_SHORT   = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_FEB     = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_FEB_LP  = 5'd29;

    // controller to datapath
    typedef struct packed {
        logic               load;
        logic               reduce;
        logic [STAGE_W-1:0] stage;
        logic               step;
        logic               out_load;
        logic               out_ovf;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic cmd_count;
        logic at_target;
        logic cnt_full;
        logic add_done;
        logic step_blocked;
    } t_dp_status;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? DAYS_FEB_LP : DAYS_FEB;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = DAYS_LONG;
            default: len = DAYS_SHORT;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/cds_ctrl.sv
// controller state machine for the calendar date stepper
module cds_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output cds_pkg::t_dp_cmd    o_cmd,
    input  cds_pkg::t_dp_status i_status
);
    import cds_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_RUN,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic               r_ovf, n_ovf;
    logic               r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        n_ovf   = r_ovf;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_stage    = REDUCE_TOP;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                o_cmd.stage  = r_stage;
                if (r_stage == '0) begin
                    n_state = S_RUN;
                end else begin
                    n_stage = r_stage - 1'b1;
                end
            end
            S_RUN: begin
                if (i_status.cmd_count) begin
                    if (i_status.at_target) begin
                        n_ovf   = 1'b0;
                        n_state = S_DONE;
                    end else if (i_status.cnt_full || i_status.step_blocked) begin
                        n_ovf   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    if (i_status.add_done) begin
                        n_ovf   = 1'b0;
                        n_state = S_DONE;
                    end else if (i_status.step_blocked) begin
                        n_ovf   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ovf  = r_ovf;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> rtl/cds_datapath.sv
// date registers, year reduction, day stepping and output word register
module cds_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  cds_pkg::t_dp_cmd             i_cmd,
    output cds_pkg::t_dp_status          o_status,
    input  logic                         i_command,
    input  logic [cds_pkg::DAY_W-1:0]    i_start_day,
    input  logic [cds_pkg::MONTH_W-1:0]  i_start_month,
    input  logic [cds_pkg::YEAR_W-1:0]   i_start_year,
    input  logic [cds_pkg::DAYS_W-1:0]   i_days_to_add,
    input  logic [cds_pkg::DAY_W-1:0]    i_target_day,
    input  logic [cds_pkg::MONTH_W-1:0]  i_target_month,
    input  logic [cds_pkg::YEAR_W-1:0]   i_target_year,
    output logic [cds_pkg::DAY_W-1:0]    o_result_day,
    output logic [cds_pkg::MONTH_W-1:0]  o_result_month,
    output logic [cds_pkg::YEAR_W-1:0]   o_result_year,
    output logic [cds_pkg::DAYS_W-1:0]   o_days_between,
    output logic                         o_overflow
);
    import cds_pkg::*;

    logic                  r_cmd;
    logic [DAY_W-1:0]      r_day, r_tgt_day;
    logic [MONTH_W-1:0]    r_month, r_tgt_month;
    logic [YEAR_W-1:0]     r_year, r_tgt_year;
    logic [YEAR_W-1:0]     r_rem;
    logic [DAYS_W-1:0]     r_remaining;
    logic [COUNT_BITS-1:0] r_count;

    logic [DAY_W-1:0]      r_out_day;
    logic [MONTH_W-1:0]    r_out_month;
    logic [YEAR_W-1:0]     r_out_year;
    logic [DAYS_W-1:0]     r_out_days;
    logic                  r_out_ovf;

    logic [REM_W-1:0]      w_rem400;
    logic                  w_leap;
    logic [DAY_W-1:0]      w_mlen;
    logic                  w_month_end;
    logic                  w_year_end;
    logic [YEAR_W-1:0]     w_divisor;
    logic [DAYS_W-1:0]     w_count_out;

    // year mod 400 sits in the low bits of the reduced remainder
    assign w_rem400 = r_rem[REM_W-1:0];
    assign w_leap   = (w_rem400 == '0) ||
                      (!(w_rem400 == CENTURY_1 || w_rem400 == CENTURY_2 ||
                         w_rem400 == CENTURY_3) && (r_year[1:0] == 2'b00));
    assign w_mlen      = month_len(r_month, w_leap);
    assign w_month_end = (r_day >= w_mlen);
    assign w_year_end  = (r_month >= MONTH_DEC);
    assign w_divisor   = YEAR_W'(LEAP_CYCLE) << i_cmd.stage;

    assign o_status.cmd_count    = r_cmd;
    assign o_status.at_target    = (r_day == r_tgt_day) && (r_month == r_tgt_month) &&
                                   (r_year == r_tgt_year);
    assign o_status.cnt_full     = &r_count;
    assign o_status.add_done     = (r_remaining == '0);
    assign o_status.step_blocked = w_month_end && w_year_end && (r_year >= YEAR_LIMIT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd       <= i_command;
            r_day       <= i_start_day;
            r_month     <= i_start_month;
            r_year      <= i_start_year;
            r_rem       <= i_start_year;
            r_tgt_day   <= i_target_day;
            r_tgt_month <= i_target_month;
            r_tgt_year  <= i_target_year;
            r_remaining <= i_days_to_add;
            r_count     <= '0;
        end else if (i_cmd.reduce) begin
            if (r_rem >= w_divisor) begin
                r_rem <= r_rem - w_divisor;
            end
        end else if (i_cmd.step) begin
            if (w_month_end) begin
                r_day <= DAY_FIRST;
                if (w_year_end) begin
                    r_month <= MONTH_JAN;
                    r_year  <= r_year + 1'b1;
                    r_rem   <= (w_rem400 == REM_LAST) ? '0 : r_rem + 1'b1;
                end else begin
                    r_month <= r_month + 1'b1;
                end
            end else begin
                r_day <= r_day + 1'b1;
            end
            if (r_cmd) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_remaining <= r_remaining - 1'b1;
            end
        end
    end

    generate
        if (COUNT_BITS >= DAYS_W) begin : g_cnt_trunc
            assign w_count_out = r_count[DAYS_W-1:0];
        end else begin : g_cnt_ext
            assign w_count_out = {{(DAYS_W-COUNT_BITS){1'b0}}, r_count};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_day   <= r_day;
            r_out_month <= r_month;
            r_out_year  <= r_year;
            r_out_days  <= w_count_out;
            r_out_ovf   <= i_cmd.out_ovf;
        end
    end

    assign o_result_day   = r_out_day;
    assign o_result_month = r_out_month;
    assign o_result_year  = r_out_year;
    assign o_days_between = r_out_days;
    assign o_overflow     = r_out_ovf;

endmodule

>>> rtl/calendar_date_stepper.sv
// top level of the calendar date stepper: controller plus datapath
// Steps a Gregorian date forward one day per clock. Command 0 adds
// i_days_to_add days to the start date; command 1 counts days from the start
// date until the target date is reached. Stepping stops with o_overflow set
// if the year would pass 9999, or (command 1) if the count reaches
// 2^COUNT_BITS - 1 without meeting the target, which covers a target before
// the start. One word is worked on at a time: after acceptance, the year
// reduction reduces the start year modulo 400 for the leap rule (one
// restoring compare and subtract per cycle), then the single day-step unit
// runs one day per cycle until a closing check sees the target, the end of
// the added days or an overflow, then the output register is written once
// it is free of an earlier result. The output register lets the next word
// be accepted while a result still waits for i_ready.
module calendar_date_stepper #(
    parameter int COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_command,
    input  logic [cds_pkg::DAY_W-1:0]    i_start_day,
    input  logic [cds_pkg::MONTH_W-1:0]  i_start_month,
    input  logic [cds_pkg::YEAR_W-1:0]   i_start_year,
    input  logic [cds_pkg::DAYS_W-1:0]   i_days_to_add,
    input  logic [cds_pkg::DAY_W-1:0]    i_target_day,
    input  logic [cds_pkg::MONTH_W-1:0]  i_target_month,
    input  logic [cds_pkg::YEAR_W-1:0]   i_target_year,
    // output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [cds_pkg::DAY_W-1:0]    o_result_day,
    output logic [cds_pkg::MONTH_W-1:0]  o_result_month,
    output logic [cds_pkg::YEAR_W-1:0]   o_result_year,
    output logic [cds_pkg::DAYS_W-1:0]   o_days_between,
    output logic                         o_overflow
);
    import cds_pkg::*;

    // command and status between controller and datapath
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer: accept, year reduction, stepping, output write
    cds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // date registers, day-step unit, counters and output register
    cds_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_command      (i_command),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_days_to_add  (i_days_to_add),
        .i_target_day   (i_target_day),
        .i_target_month (i_target_month),
        .i_target_year  (i_target_year),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_days_between (o_days_between),
        .o_overflow     (o_overflow)
    );

endmodule
